/* sv/tlvawc_pkg.sv */
// Shared types, codes and the attribute kind table for the TLV attribute walker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tlvawc_pkg;

  localparam int unsigned SKIP_W = 12;

  localparam logic [2:0] KIND_STR = 3'd0;
  localparam logic [2:0] KIND_HEX = 3'd1;
  localparam logic [2:0] KIND_INT = 3'd2;
  localparam logic [2:0] KIND_ADR = 3'd3;
  localparam logic [2:0] KIND_UNK = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CORRUPT = 3'd1;
  localparam logic [2:0] ST_BADLEN  = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_NOATTR  = 3'd4;

  localparam int unsigned KIND_DEPTH = 92;
  localparam int unsigned KIND_IDX_W = $clog2(KIND_DEPTH);

  localparam logic [2:0] KIND_TABLE [0:KIND_DEPTH-1] = '{
    3'd4, 3'd0, 3'd0, 3'd0, 3'd3, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
    3'd2, 3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd4, 3'd0, 3'd0,
    3'd0, 3'd4, 3'd0, 3'd2, 3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd2,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd0,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd0, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd0, 3'd2, 3'd2, 3'd2, 3'd4, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd0, 3'd2, 3'd2, 3'd1, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd2, 3'd0, 3'd2, 3'd2, 3'd0, 3'd0, 3'd4,
    3'd0, 3'd0
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pkt_byte_t;

  typedef struct packed {
    logic [7:0]  attr_type;
    logic [7:0]  value_length;
    logic [2:0]  attr_kind;
    logic [2:0]  status;
    logic [31:0] value_word;
    logic        packet_end;
  } attr_rec_t;

  function automatic logic [2:0] kind_of(input logic [7:0] code);
    logic [2:0] k;
    k = KIND_UNK;
    if (code < 8'(KIND_DEPTH)) begin
      k = KIND_TABLE[code[KIND_IDX_W-1:0]];
    end
    return k;
  endfunction

endpackage

/* sv/tlvawc_in_stage.sv */
// Input register stage: holds one packet byte transaction ahead of the walker.
// Depends on tlvawc_pkg.
`timescale 1ns / 1ps

module tlvawc_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pkt_valid,
  output logic                  pkt_ready,
  input  tlvawc_pkg::pkt_byte_t pkt,
  output logic                  stage_valid,
  output tlvawc_pkg::pkt_byte_t stage_item,
  input  logic                  stage_take
);
  import tlvawc_pkg::*;

  // refill whenever empty or the held byte is consumed this cycle
  assign pkt_ready = !stage_valid || stage_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (pkt_ready) begin
      stage_valid <= pkt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_ready && pkt_valid) begin
      stage_item <= pkt;
    end
  end

endmodule

/* sv/tlvawc_walker.sv */
// Attribute walker: parse state, per-byte update logic and the record register.
// Depends on tlvawc_pkg.
`timescale 1ns / 1ps

module tlvawc_walker #(
  parameter int unsigned PACKET_MAX = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tlvawc_pkg::SKIP_W-1:0] cfg_header_skip,
  input  logic                          stage_valid,
  input  tlvawc_pkg::pkt_byte_t         stage_item,
  output logic                          stage_take,
  output logic                          rec_valid,
  input  logic                          rec_ready,
  output tlvawc_pkg::attr_rec_t         rec
);
  import tlvawc_pkg::*;

  localparam int unsigned OFF_W = ($clog2(PACKET_MAX) < SKIP_W) ? $clog2(PACKET_MAX) : SKIP_W;
  localparam int unsigned CAP_I = ((PACKET_MAX - 1) < 4095) ? (PACKET_MAX - 1) : 4095;
  localparam logic [OFF_W-1:0] OFF_CAP = OFF_W'(CAP_I);

  localparam logic [2:0] PH_SKIP  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_VALUE = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  logic [SKIP_W-1:0] header_skip;
  logic [OFF_W-1:0]  byte_offset, byte_offset_next;
  logic [2:0]        phase, phase_next, work_phase;
  logic [7:0]        cur_type, cur_type_next;
  logic [7:0]        bytes_rem, bytes_rem_next, rem_dec;
  logic [7:0]        cur_len, cur_len_next;
  logic [31:0]       accum, accum_next, accum_upd;
  logic              emit;
  attr_rec_t         rec_next;
  logic [2:0]        cur_kind;
  logic              in_header;
  logic [7:0]        b;
  logic              last;

  assign cfg_ready  = 1'b1;
  assign stage_take = stage_valid && (!rec_valid || rec_ready);

  assign b         = stage_item.data_byte;
  assign last      = stage_item.last_byte;
  assign in_header = (phase == PH_SKIP) && (SKIP_W'(byte_offset) < header_skip);
  assign work_phase = (phase == PH_SKIP) ? PH_TYPE : phase;
  assign cur_kind  = kind_of(cur_type);
  assign rem_dec   = bytes_rem - 8'd1;
  // only the first four value bytes are gathered
  assign accum_upd = ((cur_len - bytes_rem) < 8'd4) ? {accum[23:0], b} : accum;

  always_comb begin
    byte_offset_next = (byte_offset < OFF_CAP) ? byte_offset + 1'b1 : byte_offset;
    phase_next       = phase;
    cur_type_next    = cur_type;
    bytes_rem_next   = bytes_rem;
    cur_len_next     = cur_len;
    accum_next       = accum;
    emit             = 1'b0;
    rec_next         = '{attr_type: 8'd0, value_length: 8'd0, attr_kind: KIND_UNK,
                         status: ST_NOATTR, value_word: 32'd0, packet_end: last};
    if (in_header) begin
      emit = last;
    end else begin
      unique case (work_phase)
        PH_TYPE: begin
          cur_type_next = b;
          phase_next    = PH_LEN;
          emit          = last;
          rec_next.attr_type = b;
          rec_next.attr_kind = kind_of(b);
          rec_next.status    = ST_TRUNC;
        end
        PH_LEN: begin
          rec_next.attr_type = cur_type;
          rec_next.attr_kind = cur_kind;
          if (b <= 8'd2) begin
            emit            = 1'b1;
            rec_next.status = ST_BADLEN;
            phase_next      = PH_STOP;
          end else begin
            cur_len_next   = b - 8'd2;
            bytes_rem_next = b - 8'd2;
            accum_next     = '0;
            phase_next     = PH_VALUE;
            emit           = last;
            rec_next.status       = ST_TRUNC;
            rec_next.value_length = b - 8'd2;
          end
        end
        PH_VALUE: begin
          accum_next     = accum_upd;
          bytes_rem_next = rem_dec;
          rec_next.attr_type    = cur_type;
          rec_next.attr_kind    = cur_kind;
          rec_next.value_length = cur_len;
          rec_next.value_word   = accum_upd;
          if (rem_dec == 8'd0) begin
            emit       = 1'b1;
            phase_next = PH_TYPE;
            if ((cur_kind == KIND_INT || cur_kind == KIND_ADR) && cur_len != 8'd4) begin
              rec_next.status = ST_CORRUPT;
            end else begin
              rec_next.status = ST_OK;
            end
          end else begin
            emit            = last;
            rec_next.status = ST_TRUNC;
          end
        end
        default: begin
          phase_next = PH_STOP;
          emit       = last;
        end
      endcase
    end
    if (last) begin
      byte_offset_next = '0;
      phase_next       = PH_SKIP;
      cur_type_next    = '0;
      bytes_rem_next   = '0;
      cur_len_next     = '0;
      accum_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_skip <= SKIP_W'(20);
      byte_offset <= '0;
      phase       <= PH_SKIP;
      cur_type    <= '0;
      bytes_rem   <= '0;
      cur_len     <= '0;
      accum       <= '0;
      rec_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        header_skip <= cfg_header_skip;
      end
      if (stage_take) begin
        byte_offset <= byte_offset_next;
        phase       <= phase_next;
        cur_type    <= cur_type_next;
        bytes_rem   <= bytes_rem_next;
        cur_len     <= cur_len_next;
        accum       <= accum_next;
        rec_valid   <= emit;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && emit) begin
      rec <= rec_next;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    stage_take && last |=> phase == PH_SKIP && byte_offset == '0)
    else $error("walker did not restart after last byte");

  a_value_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_VALUE |-> bytes_rem != 8'd0)
    else $error("value phase with nothing remaining");

  a_noattr_form: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec.status == ST_NOATTR |-> rec.attr_type == 8'd0 && rec.packet_end)
    else $error("malformed end record");

  a_trunc_end: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec.status == ST_TRUNC |-> rec.packet_end)
    else $error("truncation record without packet end");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    stage_valid && rec_valid && !rec_ready |=> $stable(phase) && $stable(byte_offset))
    else $error("state moved while output stalled");

endmodule

/* sv/tlv_attribute_walker_classifier.sv */
// Top level of the TLV attribute walker and classifier.
// A record is loaded into the walker's record register when the walker takes its causing byte from the input register.
// Throughput: one byte per cycle while records are taken; a record left waiting
// stalls the walker, and the input register takes one more byte before pkt_ready drops.
// Reset (rst, synchronous): walker to the header skip phase, header_skip to 20.
// Depends on tlvawc_pkg, tlvawc_in_stage and tlvawc_walker.
`timescale 1ns / 1ps

module tlv_attribute_walker_classifier #(
  parameter int unsigned PACKET_MAX = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tlvawc_pkg::SKIP_W-1:0] cfg_header_skip,
  input  logic                          pkt_valid,
  output logic                          pkt_ready,
  input  tlvawc_pkg::pkt_byte_t         pkt,
  output logic                          rec_valid,
  input  logic                          rec_ready,
  output tlvawc_pkg::attr_rec_t         rec
);
  import tlvawc_pkg::*;

  logic      stage_valid;
  logic      stage_take;
  pkt_byte_t stage_item;

  tlvawc_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .pkt_valid   (pkt_valid),
    .pkt_ready   (pkt_ready),
    .pkt         (pkt),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .stage_take  (stage_take)
  );

  tlvawc_walker #(
    .PACKET_MAX (PACKET_MAX)
  ) u_walker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_header_skip (cfg_header_skip),
    .stage_valid     (stage_valid),
    .stage_item      (stage_item),
    .stage_take      (stage_take),
    .rec_valid       (rec_valid),
    .rec_ready       (rec_ready),
    .rec             (rec)
  );

endmodule

/* tb/tb_tlv_attribute_walker_classifier.sv */
// Self-checking bench for tlv_attribute_walker_classifier: drives packet bytes and
// predicts each attribute record in-bench. Depends on tlvawc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_tlv_attribute_walker_classifier;
  import tlvawc_pkg::*;

  localparam int PACKET_MAX = 4096;
  localparam int OFFSET_CAP = (PACKET_MAX - 1 < 4095) ? PACKET_MAX - 1 : 4095;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS_PER_PHASE = 230;
  localparam int MAX_REPORTS = 10;

  // attribute kind per type code, types 92 and up are unknown
  localparam logic [2:0] TYPE_KIND [0:91] = '{
    3'd4, 3'd0, 3'd0, 3'd0, 3'd3, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
    3'd2, 3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd4, 3'd0, 3'd0,
    3'd0, 3'd4, 3'd0, 3'd2, 3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd2,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd0,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd0, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd0, 3'd2, 3'd2, 3'd2, 3'd4, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd0, 3'd2, 3'd2, 3'd1, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd2, 3'd0, 3'd2, 3'd2, 3'd0, 3'd0, 3'd4,
    3'd0, 3'd0
  };

  typedef enum logic [2:0] {
    W_SKIP, W_TYPE, W_LEN, W_VALUE, W_STOP
  } walk_phase_e;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SKIP_W-1:0]   cfg_header_skip;
  logic                pkt_valid;
  logic                pkt_ready;
  pkt_byte_t           pkt;
  logic                rec_valid;
  logic                rec_ready;
  attr_rec_t           rec;

  // walker copy
  logic [11:0]         hdr_skip;
  logic [11:0]         w_offset;
  walk_phase_e         w_phase;
  logic [7:0]          w_type;
  logic [7:0]          w_remain;
  logic [7:0]          w_len;
  logic [31:0]         w_accum;

  attr_rec_t           pending_recs[$];
  int                  mismatch_count;
  int                  bytes_sent;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  stall_cycles_left;

  tlv_attribute_walker_classifier #(
    .PACKET_MAX(PACKET_MAX)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_header_skip(cfg_header_skip),
    .pkt_valid      (pkt_valid),
    .pkt_ready      (pkt_ready),
    .pkt            (pkt),
    .rec_valid      (rec_valid),
    .rec_ready      (rec_ready),
    .rec            (rec)
  );

  always #4 clk = ~clk;

  function automatic logic [2:0] kind_for(logic [7:0] code);
    if (code < 8'd92) return TYPE_KIND[code[6:0]];
    return KIND_UNK;
  endfunction

  function automatic void push_record(logic [7:0] code, logic [7:0] vlen, logic [2:0] st,
                                      logic [31:0] word, logic lst);
    attr_rec_t r;
    r.attr_type    = code;
    r.value_length = vlen;
    r.attr_kind    = kind_for(code);
    r.status       = st;
    r.value_word   = word;
    r.packet_end   = lst;
    pending_recs.push_back(r);
  endfunction

  function automatic void walker_restart();
    w_offset = '0;
    w_phase  = W_SKIP;
    w_type   = '0;
    w_remain = '0;
    w_len    = '0;
    w_accum  = '0;
  endfunction

  // advance the walker copy by one accepted byte, queueing any record it yields
  function automatic void walk_attribute_byte(logic [7:0] b, logic lst);
    logic [2:0] st;
    if (w_phase == W_SKIP) begin
      if (w_offset >= hdr_skip) begin
        w_phase = W_TYPE;
      end else begin
        if (w_offset < OFFSET_CAP) w_offset++;
        if (lst) begin
          push_record(8'd0, 8'd0, ST_NOATTR, 32'd0, 1'b1);
          walker_restart();
        end
        return;
      end
    end
    if (w_offset < OFFSET_CAP) w_offset++;

    case (w_phase)
      W_TYPE: begin
        w_type  = b;
        w_phase = W_LEN;
        if (lst) push_record(w_type, 8'd0, ST_TRUNC, 32'd0, 1'b1);
      end
      W_LEN: begin
        if (b <= 8'd2) begin
          push_record(w_type, 8'd0, ST_BADLEN, 32'd0, lst);
          w_phase = W_STOP;
        end else begin
          w_len    = b - 8'd2;
          w_remain = w_len;
          w_accum  = '0;
          w_phase  = W_VALUE;
          if (lst) push_record(w_type, w_len, ST_TRUNC, 32'd0, 1'b1);
        end
      end
      W_VALUE: begin
        // only the first four value bytes are gathered
        if (w_len - w_remain < 4) w_accum = {w_accum[23:0], b};
        w_remain = w_remain - 8'd1;
        if (w_remain == 8'd0) begin
          st = ST_OK;
          if ((kind_for(w_type) == KIND_INT || kind_for(w_type) == KIND_ADR) && w_len != 8'd4)
            st = ST_CORRUPT;
          push_record(w_type, w_len, st, w_accum, lst);
          w_phase = W_TYPE;
        end else if (lst) begin
          push_record(w_type, w_len, ST_TRUNC, w_accum, 1'b1);
        end
      end
      default: begin
        w_phase = W_STOP;
        if (lst) push_record(8'd0, 8'd0, ST_NOATTR, 32'd0, 1'b1);
      end
    endcase

    if (lst) walker_restart();
  endfunction

  function automatic void report_mismatch(string what, attr_rec_t want, attr_rec_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected type %0d len %0d kind %0d status %0d word %08h end %0b",
               $realtime, what, want.attr_type, want.value_length, want.attr_kind,
               want.status, want.value_word, want.packet_end);
      $display("%0t: %s: actual   type %0d len %0d kind %0d status %0d word %08h end %0b",
               $realtime, what, got.attr_type, got.value_length, got.attr_kind,
               got.status, got.value_word, got.packet_end);
    end
  endfunction

  // record checker
  always @(posedge clk) begin : check_records
    attr_rec_t want;
    if (!rst && rec_valid && rec_ready) begin
      if (pending_recs.size() == 0) begin
        report_mismatch("unexpected record", '0, rec);
      end else begin
        want = pending_recs.pop_front();
        if (rec.attr_type !== want.attr_type || rec.value_length !== want.value_length ||
            rec.attr_kind !== want.attr_kind || rec.status !== want.status ||
            rec.value_word !== want.value_word || rec.packet_end !== want.packet_end)
          report_mismatch("record mismatch", want, rec);
      end
    end
  end

  // record sink: random back-pressure plus an optional long hold
  always @(negedge clk) begin
    if (stall_cycles_left > 0) begin
      stall_cycles_left--;
      rec_ready <= 1'b0;
    end else begin
      rec_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_valid <= 1'b0;
      @(negedge clk);
    end
    pkt_valid <= 1'b1;
    pkt       <= {b, lst};
    @(posedge clk);
    while (!pkt_ready) @(posedge clk);
    walk_attribute_byte(b, lst);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] body[$]);
    for (int i = 0; i < body.size(); i++) send_byte(body[i], i == body.size() - 1);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    pkt_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_header_skip(input logic [11:0] v);
    stop_sending();
    wait_drained();
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_header_skip <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hdr_skip = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // header of random bytes, then mostly well-formed attributes; some packets cut short
  task automatic send_random_packet();
    logic [7:0] body[$];
    int n_attr;
    int len;
    int r;
    int end_at;
    bit stopped;
    for (int i = 0; i < hdr_skip; i++) body.push_back(8'($urandom_range(255)));
    n_attr  = $urandom_range(1, 5);
    stopped = 0;
    for (int a = 0; a < n_attr && !stopped; a++) begin
      if ($urandom_range(9) < 7) body.push_back(8'($urandom_range(91)));
      else body.push_back(8'($urandom_range(255)));
      r = $urandom_range(99);
      if (r < 8) len = $urandom_range(2);
      else if (r < 40) len = 6;
      else if (r < 85) len = $urandom_range(3, 12);
      else if (r < 97) len = $urandom_range(13, 40);
      else if (r < 99) len = $urandom_range(41, 254);
      else len = 255;
      body.push_back(8'(len));
      if (len <= 2) begin
        // walk stops, trailing bytes are only noise
        stopped = 1;
        repeat ($urandom_range(4)) body.push_back(8'($urandom_range(255)));
      end else begin
        repeat (len - 2) body.push_back(8'($urandom_range(255)));
      end
    end
    end_at = body.size() - 1;
    if ($urandom_range(9) == 0) end_at = $urandom_range(body.size() - 1);
    for (int i = 0; i <= end_at; i++) send_byte(body[i], i == end_at);
  endtask

  task automatic test_default_header();
    logic [7:0] body[$];
    repeat (20) body.push_back(8'($urandom_range(255)));
    body = {body, 8'd6, 8'd6, 8'h00, 8'h00, 8'h00, 8'h01};
    send_packet(body);
  endtask

  task automatic test_directed_cases();
    write_header_skip(12'd0);
    // int ok, short address, bad length then ignored bytes up to the end
    send_packet({8'd5, 8'd6, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'd8, 8'd3, 8'hC4,
                 8'd255, 8'd2, 8'h7F, 8'hFF});
    send_packet({8'd1});                                        // ends on type byte
    send_packet({8'd11, 8'd10, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05}); // ends inside value
    send_packet({8'd26, 8'd0});                                 // bad length is last
    send_packet({8'd0, 8'd3, 8'h80});                           // last completes attribute
    send_packet({8'd200, 8'd4, 8'hA5, 8'h5A});                  // unknown type
  endtask

  task automatic test_long_header();
    logic [7:0] body[$];
    write_header_skip(12'd64);
    repeat (64) body.push_back(8'($urandom_range(255)));
    body.push_back(8'd1);
    body.push_back(8'd255);
    repeat (253) body.push_back(8'($urandom_range(255)));
    body = {body, 8'd4, 8'd6, 8'hC0, 8'hA8, 8'h00, 8'h01};
    send_packet(body);
    send_packet({8'h55, 8'hAA});                                // ends in header
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [11:0] skip);
    int start;
    write_header_skip(skip);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS_PER_PHASE) send_random_packet();
  endtask

  task automatic test_output_stall();
    logic [7:0] body[$];
    stop_sending();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < hdr_skip; i++) body.push_back(8'($urandom_range(255)));
    repeat (40) body = {body, 8'($urandom_range(255)), 8'd3, 8'($urandom_range(255))};
    @(posedge clk);
    stall_cycles_left = 300;
    send_packet(body);
  endtask

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    cfg_valid         = 1'b0;
    cfg_header_skip   = '0;
    pkt_valid         = 1'b0;
    pkt               = '0;
    rec_ready         = 1'b0;
    mismatch_count    = 0;
    bytes_sent        = 0;
    send_idle_pct     = 27;
    recv_idle_pct     = 63;
    stall_cycles_left = 0;
    hdr_skip          = 12'd20;
    walker_restart();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_header();
    test_directed_cases();
    test_long_header();
    test_random_traffic(27, 63, 12'd4);
    test_random_traffic(63, 27, 12'd1);
    test_random_traffic(0, 0, 12'($urandom_range(12)));
    test_output_stall();

    stop_sending();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
